[rtl/crds_pkg.sv]
// ----------------------------------------------------------------------------
// crds_pkg
// Shared constants and types of the command/response download sequencer:
// command codes, send codes, phase codes, sequencer steps and the result beat.
// ----------------------------------------------------------------------------
package crds_pkg;

  // Field widths fixed by the interface
  localparam int unsigned CmdWidth     = 2;
  localparam int unsigned ValueWidth   = 16;
  localparam int unsigned ArgWidth     = 32;
  localparam int unsigned CodeWidth    = 4;
  localparam int unsigned PhaseWidth   = 2;
  localparam int unsigned TimeoutWidth = 16;
  localparam int unsigned ElapsedWidth = 17;
  localparam int unsigned StepWidth    = 4;

  // Default widths and register reset
  localparam int unsigned        DefaultCountWidth = 16;
  localparam logic [TimeoutWidth-1:0] TimeoutReset = 16'd1000;

  // Input commands
  localparam logic [CmdWidth-1:0] CmdTick  = 2'd0;
  localparam logic [CmdWidth-1:0] CmdStart = 2'd1;
  localparam logic [CmdWidth-1:0] CmdReply = 2'd2;

  // Commands sent to the peer
  localparam logic [CodeWidth-1:0] CodeHello = 4'd0;
  localparam logic [CodeWidth-1:0] CodeInfo  = 4'd1;
  localparam logic [CodeWidth-1:0] CodeCount = 4'd2;
  localparam logic [CodeWidth-1:0] CodeBegin = 4'd3;
  localparam logic [CodeWidth-1:0] CodeNext  = 4'd4;
  localparam logic [CodeWidth-1:0] CodeEnd   = 4'd5;
  localparam logic [CodeWidth-1:0] CodeTime  = 4'd6;
  localparam logic [CodeWidth-1:0] CodeNflt  = 4'd7;
  localparam logic [CodeWidth-1:0] CodeBye   = 4'd8;

  // Reported phase
  localparam logic [PhaseWidth-1:0] PhaseIdle = 2'd0;
  localparam logic [PhaseWidth-1:0] PhaseBusy = 2'd1;
  localparam logic [PhaseWidth-1:0] PhaseDone = 2'd2;
  localparam logic [PhaseWidth-1:0] PhaseErr  = 2'd3;

  // Sequencer steps
  localparam logic [StepWidth-1:0] StIdle   = 4'd0;
  localparam logic [StepWidth-1:0] StWHello = 4'd1;
  localparam logic [StepWidth-1:0] StWInfo  = 4'd2;
  localparam logic [StepWidth-1:0] StWCount = 4'd3;
  localparam logic [StepWidth-1:0] StWBegin = 4'd4;
  localparam logic [StepWidth-1:0] StWNext  = 4'd5;
  localparam logic [StepWidth-1:0] StWEnd   = 4'd6;
  localparam logic [StepWidth-1:0] StWTime  = 4'd7;
  localparam logic [StepWidth-1:0] StWNflt  = 4'd8;
  localparam logic [StepWidth-1:0] StWBye   = 4'd9;
  localparam logic [StepWidth-1:0] StDone   = 4'd10;
  localparam logic [StepWidth-1:0] StErr    = 4'd11;

  localparam logic [ElapsedWidth-1:0] ElapsedMax = {ElapsedWidth{1'b1}};

  // One result beat
  typedef struct packed {
    logic                  send_valid;
    logic [CodeWidth-1:0]  send_code;
    logic [ArgWidth-1:0]   send_argument;
    logic [PhaseWidth-1:0] phase;
    logic                  sample_received;
    logic [ValueWidth-1:0] sample_index;
    logic [ValueWidth-1:0] sample_total;
  } crds_result_t;

endpackage

[rtl/crds_seq.sv]
// ----------------------------------------------------------------------------
// crds_seq
// Sequencer state and transition logic. On each advance it takes one item,
// updates step, timer and sample counters, and presents the result beat.
// ----------------------------------------------------------------------------
module crds_seq #(
  parameter int unsigned COUNT_WIDTH = crds_pkg::DefaultCountWidth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             adv_i,
  input  logic [crds_pkg::CmdWidth-1:0]     cmd_i,
  input  logic [crds_pkg::ValueWidth-1:0]   reply_value_i,
  input  logic [crds_pkg::ArgWidth-1:0]     rtc_time_i,
  input  logic [crds_pkg::ArgWidth-1:0]     next_flight_time_i,
  input  logic [crds_pkg::TimeoutWidth-1:0] timeout_i,
  output crds_pkg::crds_result_t           result_o
);
  import crds_pkg::*;

  logic [StepWidth-1:0]    step_q, step_d;
  logic [ElapsedWidth-1:0] elapsed_q, elapsed_d;
  logic [COUNT_WIDTH-1:0]  expected_q, expected_d;
  logic [COUNT_WIDTH-1:0]  done_q, done_d;

  logic                    waiting;
  logic [ElapsedWidth-1:0] elapsed_inc;
  logic [COUNT_WIDTH-1:0]  done_next;
  logic                    send;
  logic [CodeWidth-1:0]    code;
  logic [ArgWidth-1:0]     arg;
  logic                    sample;
  logic [PhaseWidth-1:0]   phase;

  assign waiting     = (step_q >= StWHello) && (step_q <= StWBye);
  // Saturate the timer at its top value
  assign elapsed_inc = (elapsed_q != ElapsedMax) ? elapsed_q + 1'b1 : elapsed_q;
  // Count a sample only when the reply answers a NEXT
  assign done_next   = (step_q == StWNext) ? done_q + 1'b1 : done_q;

  // Next state and outgoing command
  always_comb begin
    step_d     = step_q;
    elapsed_d  = elapsed_q;
    expected_d = expected_q;
    done_d     = done_q;
    send       = 1'b0;
    code       = CodeHello;
    arg        = '0;
    sample     = 1'b0;
    case (cmd_i)
      CmdStart: begin
        send      = 1'b1;
        code      = CodeHello;
        step_d    = StWHello;
        elapsed_d = '0;
      end
      CmdTick: begin
        if (waiting) begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc > {1'b0, timeout_i}) begin
            step_d = StErr;
          end
        end
      end
      CmdReply: begin
        if (waiting) begin
          elapsed_d = '0;
          send      = 1'b1;
          case (step_q)
            StWHello: begin
              code   = CodeInfo;
              step_d = StWInfo;
            end
            StWInfo: begin
              code   = CodeCount;
              step_d = StWCount;
            end
            StWCount: begin
              expected_d = COUNT_WIDTH'(reply_value_i);
              done_d     = '0;
              code       = CodeBegin;
              step_d     = StWBegin;
            end
            StWBegin, StWNext: begin
              done_d = done_next;
              sample = (step_q == StWNext);
              if (done_next >= expected_q) begin
                code   = CodeEnd;
                step_d = StWEnd;
              end else begin
                code   = CodeNext;
                step_d = StWNext;
              end
            end
            StWEnd: begin
              code   = CodeTime;
              arg    = rtc_time_i;
              step_d = StWTime;
            end
            StWTime: begin
              code   = CodeNflt;
              arg    = next_flight_time_i;
              step_d = StWNflt;
            end
            StWNflt: begin
              code   = CodeBye;
              step_d = StWBye;
            end
            default: begin
              send   = 1'b0;
              step_d = StDone;
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  // Phase after this item
  always_comb begin
    case (step_d)
      StIdle:  phase = PhaseIdle;
      StDone:  phase = PhaseDone;
      StErr:   phase = PhaseErr;
      default: phase = PhaseBusy;
    endcase
  end

  assign result_o.send_valid      = send;
  assign result_o.send_code       = code;
  assign result_o.send_argument   = arg;
  assign result_o.phase           = phase;
  assign result_o.sample_received = sample;
  assign result_o.sample_index    = ValueWidth'(done_d);
  assign result_o.sample_total    = ValueWidth'(expected_d);

  // Commit state on advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= StIdle;
      elapsed_q  <= '0;
      expected_q <= '0;
      done_q     <= '0;
    end else if (adv_i) begin
      step_q     <= step_d;
      elapsed_q  <= elapsed_d;
      expected_q <= expected_d;
      done_q     <= done_d;
    end
  end

endmodule

[rtl/command_response_download_sequencer_top.sv]
// ----------------------------------------------------------------------------
// command_response_download_sequencer_top
// Host side of a fixed command/response download exchange with a peer.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------
//   in      | input     | in_valid_i / in_stall_o | command, reply, rtc, nflt
//   out     | output    | out_valid_o/ out_stall_i| send_*, phase, sample_*
//   cfg     | input     | cfg_valid_i/ cfg_ready_o| reply timeout (ticks)
//
// Items pass the input register, then the result register. One item is
// accepted per cycle unless the output stalls; the sequencer state registers
// close the loop. A stalled output holds the result register and, once the
// input register is also full, stalls the input side. Reset returns the
// sequencer to idle and the timeout to 1000 ticks. Config is always ready.
// ----------------------------------------------------------------------------
module command_response_download_sequencer_top #(
  parameter int unsigned COUNT_WIDTH = crds_pkg::DefaultCountWidth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [crds_pkg::CmdWidth-1:0]     command_i,
  input  logic [crds_pkg::ValueWidth-1:0]   reply_value_i,
  input  logic [crds_pkg::ArgWidth-1:0]     rtc_time_i,
  input  logic [crds_pkg::ArgWidth-1:0]     next_flight_time_i,
  // Output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              send_valid_o,
  output logic [crds_pkg::CodeWidth-1:0]    send_code_o,
  output logic [crds_pkg::ArgWidth-1:0]     send_argument_o,
  output logic [crds_pkg::PhaseWidth-1:0]   phase_o,
  output logic                              sample_received_o,
  output logic [crds_pkg::ValueWidth-1:0]   sample_index_o,
  output logic [crds_pkg::ValueWidth-1:0]   sample_total_o,
  // Configuration channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [crds_pkg::TimeoutWidth-1:0] cfg_data_i
);
  import crds_pkg::*;

  logic                    in_vld_q;
  logic [CmdWidth-1:0]     cmd_q;
  logic [ValueWidth-1:0]   value_q;
  logic [ArgWidth-1:0]     rtc_q;
  logic [ArgWidth-1:0]     nflt_q;
  logic [TimeoutWidth-1:0] timeout_q;
  logic                    out_vld_q;
  crds_result_t            res_q;
  crds_result_t            res;
  logic                    out_free;
  logic                    adv;
  logic                    in_take;

  // Pipeline control
  assign out_free   = !out_vld_q || !out_stall_i;
  assign adv        = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      timeout_q <= cfg_data_i;
    end
  end

  // Input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  // Capture input beat
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q   <= command_i;
      value_q <= reply_value_i;
      rtc_q   <= rtc_time_i;
      nflt_q  <= next_flight_time_i;
    end
  end

  crds_seq #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_seq (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .adv_i             (adv),
    .cmd_i             (cmd_q),
    .reply_value_i     (value_q),
    .rtc_time_i        (rtc_q),
    .next_flight_time_i(nflt_q),
    .timeout_i         (timeout_q),
    .result_o          (res)
  );

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= adv;
    end
  end

  // Hold result beat until taken
  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign send_valid_o      = res_q.send_valid;
  assign send_code_o       = res_q.send_code;
  assign send_argument_o   = res_q.send_argument;
  assign phase_o           = res_q.phase;
  assign sample_received_o = res_q.sample_received;
  assign sample_index_o    = res_q.sample_index;
  assign sample_total_o    = res_q.sample_total;

endmodule
